@@ sv/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define RTPW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtpw: implication check failed");

// antecedent implies consequent in the next cycle
`define RTPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpw: next-cycle check failed");

`endif

@@ sv/rtpw_pkg.sv @@
// shared types and constants for the rotated two-plane pixel writer
package rtpw_pkg;

    localparam int PANEL_WIDTH_DEF  = 264;
    localparam int PANEL_HEIGHT_DEF = 176;

    localparam int COORD_W    = 11;
    localparam int SHADE_W    = 2;
    localparam int ROT_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int ADDR_OUT_W = 13;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - (1 + ADDR_OUT_W + 2 * BYTE_W);

    typedef struct packed {
        logic clear_en;
        logic load_in;
        logic calc_en;
        logic mul_en;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

@@ sv/rtpw_ram.sv @@
// generic simple dual-port ram with registered read
module rtpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/rtpw_ctrl.sv @@
// sequencing controller: plane clearing and per-pixel read-modify-write steps
module rtpw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rtpw_pkg::status_t status,
    output rtpw_pkg::cmd_t    cmd
);

    import rtpw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_READ,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc_en = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/rtpw_dp.sv @@
// datapath: coordinate rotation, address multiply, plane stores and result register
module rtpw_dp #(
    parameter int PANEL_WIDTH  = rtpw_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = rtpw_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtpw_pkg::cmd_t                     cmd,
    output rtpw_pkg::status_t                  status,
    input  logic [rtpw_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               cfg_valid,
    input  logic [rtpw_pkg::ROT_W-1:0]         cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rtpw_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import rtpw_pkg::*;

    localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int AW = $clog2(PLANE_BYTES);
    localparam int PW = AW + 3;
    localparam int DW = $clog2(PANEL_WIDTH);
    localparam int HW = $clog2(PANEL_HEIGHT);
    localparam logic [COORD_W-1:0] W_C   = COORD_W'(PANEL_WIDTH);
    localparam logic [COORD_W-1:0] H_C   = COORD_W'(PANEL_HEIGHT);
    localparam logic [COORD_W-1:0] WM1_C = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] HM1_C = COORD_W'(PANEL_HEIGHT - 1);
    localparam logic [AW-1:0]      LAST_C = AW'(PLANE_BYTES - 1);

    logic [ROT_W-1:0]      rot_reg;
    logic [COORD_W-1:0]    ux_reg;
    logic [COORD_W-1:0]    uy_reg;
    logic [SHADE_W-1:0]    shade_reg;
    logic [DW-1:0]         d_reg;
    logic [HW-1:0]         py_reg;
    logic                  inb_reg;
    logic [AW-1:0]         addr_reg;
    logic [2:0]            bit_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic                  out_valid_reg;
    logic                  drawn_reg;
    logic [ADDR_OUT_W-1:0] byte_addr_reg;
    logic [BYTE_W-1:0]     first_byte_reg;
    logic [BYTE_W-1:0]     second_byte_reg;

    logic [COORD_W-1:0]    vis_w;
    logic [COORD_W-1:0]    vis_h;
    logic                  inb_calc;
    logic [COORD_W-1:0]    d_full;
    logic [COORD_W-1:0]    py_full;
    logic [PW-1:0]         prod;
    logic [AW+ADDR_OUT_W-1:0] addr_wide;
    logic [BYTE_W-1:0]     mask;
    logic [BYTE_W-1:0]     rd_first;
    logic [BYTE_W-1:0]     rd_second;
    logic [BYTE_W-1:0]     new_first;
    logic [BYTE_W-1:0]     new_second;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [BYTE_W-1:0]     ram_wdata_first;
    logic [BYTE_W-1:0]     ram_wdata_second;

    // bounds and quarter-turn mapping; d is the column distance from the panel's right edge
    always_comb
    begin
        vis_w    = rot_reg[0] ? H_C : W_C;
        vis_h    = rot_reg[0] ? W_C : H_C;
        inb_calc = !ux_reg[COORD_W-1] && !uy_reg[COORD_W-1] && (ux_reg < vis_w)
                   && (uy_reg < vis_h);
        unique case (rot_reg)
            2'd0:
            begin
                d_full  = WM1_C - ux_reg;
                py_full = uy_reg;
            end
            2'd1:
            begin
                d_full  = uy_reg;
                py_full = ux_reg;
            end
            2'd2:
            begin
                d_full  = ux_reg;
                py_full = HM1_C - uy_reg;
            end
            default:
            begin
                d_full  = WM1_C - uy_reg;
                py_full = HM1_C - ux_reg;
            end
        endcase
    end

    assign prod      = PW'(d_reg) * PW'(PANEL_HEIGHT) + PW'(py_reg);
    assign addr_wide = (AW + ADDR_OUT_W)'(addr_reg);

    assign mask       = BYTE_W'(8'h80 >> bit_reg);
    assign new_first  = shade_reg[0] ? (rd_first | mask) : (rd_first & ~mask);
    assign new_second = shade_reg[1] ? (rd_second | mask) : (rd_second & ~mask);

    assign ram_we           = cmd.clear_en || (cmd.commit && inb_reg);
    assign ram_re           = cmd.rd_en && inb_reg;
    assign ram_waddr        = cmd.clear_en ? clr_cnt_reg : addr_reg;
    assign ram_wdata_first  = cmd.clear_en ? '0 : new_first;
    assign ram_wdata_second = cmd.clear_en ? '0 : new_second;

    rtpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PLANE_BYTES)
    ) u_first_plane (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata_first),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (rd_first)
    );

    rtpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PLANE_BYTES)
    ) u_second_plane (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata_second),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (rd_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                rot_reg <= cfg_data;
            end
            if (cmd.clear_en && !status.clear_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ux_reg    <= s_tdata[COORD_W-1:0];
            uy_reg    <= s_tdata[2*COORD_W-1:COORD_W];
            shade_reg <= s_tdata[2*COORD_W+SHADE_W-1:2*COORD_W];
        end
        if (cmd.calc_en)
        begin
            inb_reg <= inb_calc;
            d_reg   <= d_full[DW-1:0];
            py_reg  <= py_full[HW-1:0];
        end
        if (cmd.mul_en)
        begin
            addr_reg <= prod[PW-1:3];
            bit_reg  <= py_reg[2:0];
        end
        if (cmd.commit)
        begin
            drawn_reg       <= inb_reg;
            byte_addr_reg   <= inb_reg ? addr_wide[ADDR_OUT_W-1:0] : '0;
            first_byte_reg  <= inb_reg ? new_first : '0;
            second_byte_reg <= inb_reg ? new_second : '0;
        end
    end

    assign status.clear_last = (clr_cnt_reg == LAST_C);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), second_byte_reg, first_byte_reg, byte_addr_reg,
                       drawn_reg};

endmodule

@@ sv/rotated_two_plane_pixel_writer.sv @@
// top level of the rotated two-plane pixel writer
// Plots one 2-bit gray pixel per input transfer into two panel-sized bit planes,
// after turning the user coordinates by the rotation register (quarter turns).
// Each accepted pixel goes through four steps (bounds and rotation, address
// multiply, plane read, modify and write), set by the single read-modify-write
// sequence over the two plane memories; the write step waits for a free output
// register and loads the result into it. A new pixel is taken the cycle after the
// previous result is loaded into the output register, so a new pixel is never taken
// while one is in flight; the result waits there for the downstream side. After reset
// both planes are swept to white once, one byte per cycle over all
// (PANEL_WIDTH*PANEL_HEIGHT+7)/8 bytes of each plane (5808 at the default size), and
// no pixel is taken until that is done. Rotation writes are taken at any time but
// should only be made while no pixel is in flight.
module rotated_two_plane_pixel_writer #(
    parameter int PANEL_WIDTH  = rtpw_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = rtpw_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[10:0], pos_y[21:11], shade[23:22]
    input  logic [rtpw_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // drawn[0], byte_addr[13:1], first_plane_byte[21:14], second_plane_byte[29:22]
    output logic [rtpw_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtpw_pkg::ROT_W-1:0]      cfg_data
);

    import rtpw_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    rtpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtpw_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ sv/rtpw_checker.sv @@
// port-level checker for the rotated two-plane pixel writer, bound to the top level
`include "assert_macros.svh"

module rtpw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rtpw_pkg::OUT_DATA_W-1:0] m_tdata
);

    `RTPW_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid)
    `RTPW_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata))
    `RTPW_ASSERT_IMPL(a_undrawn_zero, m_tvalid && !m_tdata[0], m_tdata[29:1] == 29'd0)
    `RTPW_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

endmodule

bind rotated_two_plane_pixel_writer rtpw_checker u_rtpw_checker (.*);
